[src/dsc_pkg.sv]
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types and constants for the dual stack with compare
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsc_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = 5;
    localparam int DATA_W      = 8;
    localparam int REQ_W       = 3;

    localparam logic [REQ_W-1:0] REQ_PUSH_A  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_B  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_A   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_B   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_COMPARE = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_CMP_RD,
        ST_CMP_CHK
    } state_t;

endpackage

[src/dsc_ram.sv]
// ----------------------------------------------------------------------------
// dsc_ram
// Generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/dual_stack_with_compare.sv]
// ----------------------------------------------------------------------------
// dual_stack_with_compare
// Two bounded byte stacks with push, pop and drain-compare requests
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result word
// shows on the result ports for a single cycle with done high, the cycle after
// the request finishes, and must be captured then. Push, failed pop and unused
// codes finish in the accept cycle, so a new request can follow every cycle.
// A successful pop keeps busy high while the stack ram read completes. Compare
// keeps busy high until a stack is empty or a popped pair differs; each pair is
// read from both rams in ST_CMP_RD and its bytes are checked in ST_CMP_CHK.
// count_a and count_b always show the current fill and are valid with done.
`timescale 1ns / 1ps

module dual_stack_with_compare (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [dsc_pkg::REQ_W-1:0]   req_type,
    input  logic [dsc_pkg::DATA_W-1:0]  push_value,
    output logic                        done,
    output logic                        ok,
    output logic [dsc_pkg::DATA_W-1:0]  pop_value,
    output logic                        equal,
    output logic [dsc_pkg::CNT_W-1:0]   count_a,
    output logic [dsc_pkg::CNT_W-1:0]   count_b
);

    import dsc_pkg::*;

    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_ZERO = '0;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_a_reg, count_a_next;
    logic [CNT_W-1:0]    count_b_reg, count_b_next;
    logic                pop_sel_reg, pop_sel_next;
    logic                done_reg, done_next;
    logic                ok_reg, ok_next;
    logic [DATA_W-1:0]   pop_value_reg, pop_value_next;
    logic                equal_reg, equal_next;

    logic                we_a, we_b;
    logic [CNT_W-1:0]    dec_a, dec_b;
    logic [DATA_W-1:0]   q_a, q_b;
    logic                accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign dec_a  = count_a_reg - CNT_ONE;
    assign dec_b  = count_b_reg - CNT_ONE;

    // both rams always read the current top, so a pop or compare step sees it next cycle
    dsc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (count_a_reg[ADDR_W-1:0]),
        .wdata (push_value),
        .raddr (dec_a[ADDR_W-1:0]),
        .rdata (q_a)
    );

    dsc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (count_b_reg[ADDR_W-1:0]),
        .wdata (push_value),
        .raddr (dec_b[ADDR_W-1:0]),
        .rdata (q_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_a_reg <= '0;
            count_b_reg <= '0;
            pop_sel_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
            pop_sel_reg <= pop_sel_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg        <= ok_next;
        pop_value_reg <= pop_value_next;
        equal_reg     <= equal_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        pop_sel_next   = pop_sel_reg;
        done_next      = 1'b0;
        ok_next        = ok_reg;
        pop_value_next = pop_value_reg;
        equal_next     = equal_reg;
        we_a           = 1'b0;
        we_b           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ok_next        = 1'b0;
                    pop_value_next = '0;
                    equal_next     = 1'b0;
                    case (req_type)
                        REQ_PUSH_A:
                        begin
                            done_next = 1'b1;
                            if (count_a_reg < CNT_FULL)
                            begin
                                we_a         = 1'b1;
                                count_a_next = count_a_reg + CNT_ONE;
                                ok_next      = 1'b1;
                            end
                        end
                        REQ_PUSH_B:
                        begin
                            done_next = 1'b1;
                            if (count_b_reg < CNT_FULL)
                            begin
                                we_b         = 1'b1;
                                count_b_next = count_b_reg + CNT_ONE;
                                ok_next      = 1'b1;
                            end
                        end
                        REQ_POP_A:
                        begin
                            if (count_a_reg != CNT_ZERO)
                            begin
                                count_a_next = dec_a;
                                pop_sel_next = 1'b0;
                                state_next   = ST_POP;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        REQ_POP_B:
                        begin
                            if (count_b_reg != CNT_ZERO)
                            begin
                                count_b_next = dec_b;
                                pop_sel_next = 1'b1;
                                state_next   = ST_POP;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        REQ_COMPARE:
                        begin
                            ok_next    = 1'b1;
                            state_next = ST_CMP_RD;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_POP:
            begin
                ok_next        = 1'b1;
                pop_value_next = pop_sel_reg ? q_b : q_a;
                done_next      = 1'b1;
                state_next     = ST_IDLE;
            end

            ST_CMP_RD:
            begin
                if (count_a_reg == CNT_ZERO || count_b_reg == CNT_ZERO)
                begin
                    equal_next = (count_a_reg == CNT_ZERO) && (count_b_reg == CNT_ZERO);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // tops are read at this edge, pair is consumed either way
                    count_a_next = dec_a;
                    count_b_next = dec_b;
                    state_next   = ST_CMP_CHK;
                end
            end

            ST_CMP_CHK:
            begin
                if (q_a != q_b)
                begin
                    equal_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_CMP_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign ok        = ok_reg;
    assign pop_value = pop_value_reg;
    assign equal     = equal_reg;
    assign count_a   = count_a_reg;
    assign count_b   = count_b_reg;

endmodule

[sim/dsc_stack_checker.sv]
// ----------------------------------------------------------------------------
// dsc_stack_checker
// Predicts and checks every result word of the dual stack with compare
// ----------------------------------------------------------------------------
// Watches the request and result ports. Each accepted request is run through
// a local model of both stacks, and the predicted word is queued. Each done
// strobe is checked field by field against the oldest queued word.
`timescale 1ns / 1ps

module dsc_stack_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [dsc_pkg::REQ_W-1:0]   req_type,
    input  logic [dsc_pkg::DATA_W-1:0]  push_value,
    input  logic                        done,
    input  logic                        ok,
    input  logic [dsc_pkg::DATA_W-1:0]  pop_value,
    input  logic                        equal,
    input  logic [dsc_pkg::CNT_W-1:0]   count_a,
    input  logic [dsc_pkg::CNT_W-1:0]   count_b,
    output int                          mismatches,
    output int                          outstanding
);

    import dsc_pkg::*;

    typedef struct packed {
        logic               ok;
        logic [DATA_W-1:0]  pop_value;
        logic               equal;
        logic [CNT_W-1:0]   count_a;
        logic [CNT_W-1:0]   count_b;
    } stack_word_t;

    logic [DATA_W-1:0]  mem_a [STACK_DEPTH];
    logic [DATA_W-1:0]  mem_b [STACK_DEPTH];
    int unsigned        fill_a;
    int unsigned        fill_b;
    stack_word_t        expected_words [$];
    stack_word_t        want;

    function automatic stack_word_t stack_pair_step(input logic [REQ_W-1:0] req,
                                                    input logic [DATA_W-1:0] val);
        stack_word_t w;
        logic        differ;
        w      = '0;
        differ = 1'b0;
        case (req)
            REQ_PUSH_A:
            begin
                if (fill_a < STACK_DEPTH)
                begin
                    mem_a[fill_a[ADDR_W-1:0]] = val;
                    fill_a++;
                    w.ok = 1'b1;
                end
            end
            REQ_PUSH_B:
            begin
                if (fill_b < STACK_DEPTH)
                begin
                    mem_b[fill_b[ADDR_W-1:0]] = val;
                    fill_b++;
                    w.ok = 1'b1;
                end
            end
            REQ_POP_A:
            begin
                if (fill_a != 0)
                begin
                    fill_a--;
                    w.ok        = 1'b1;
                    w.pop_value = mem_a[fill_a[ADDR_W-1:0]];
                end
            end
            REQ_POP_B:
            begin
                if (fill_b != 0)
                begin
                    fill_b--;
                    w.ok        = 1'b1;
                    w.pop_value = mem_b[fill_b[ADDR_W-1:0]];
                end
            end
            REQ_COMPARE:
            begin
                w.ok = 1'b1;
                // pairs are popped in step; the differing pair is consumed too
                while (fill_a != 0 && fill_b != 0 && !differ)
                begin
                    fill_a--;
                    fill_b--;
                    differ = (mem_a[fill_a[ADDR_W-1:0]] != mem_b[fill_b[ADDR_W-1:0]]);
                end
                w.equal = !differ && fill_a == 0 && fill_b == 0;
            end
            default: ;
        endcase
        w.count_a = fill_a[CNT_W-1:0];
        w.count_b = fill_b[CNT_W-1:0];
        return w;
    endfunction

    function automatic void check_field(input string field, input logic [DATA_W-1:0] exp_v,
                                        input logic [DATA_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_words.delete();
            fill_a      = 0;
            fill_b      = 0;
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t ns: result word with none expected, expected none, actual %h",
                             $time, {ok, pop_value, equal, count_a, count_b});
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("ok", DATA_W'(want.ok), DATA_W'(ok));
                    check_field("pop_value", want.pop_value, pop_value);
                    check_field("equal", DATA_W'(want.equal), DATA_W'(equal));
                    check_field("count_a", DATA_W'(want.count_a), DATA_W'(count_a));
                    check_field("count_b", DATA_W'(want.count_b), DATA_W'(count_b));
                end
            end
            if (start && !busy)
                expected_words.push_back(stack_pair_step(req_type, push_value));
            outstanding <= expected_words.size();
        end
    end

endmodule

[sim/tb_dual_stack_with_compare.sv]
// ----------------------------------------------------------------------------
// tb_dual_stack_with_compare
// Stimulus and verdict for the dual stack with compare
// ----------------------------------------------------------------------------
// Runs a short directed pass over empty pops, unused codes and compare corner
// cases, then random episodes: matching fills with compare (often to full,
// with overflow pushes), broken fills, single stack fill and drain past both
// ends, and random noise. A checker beside the block predicts every word.
`timescale 1ns / 1ps

module tb_dual_stack_with_compare;
    import dsc_pkg::*;

    localparam int WORD_TARGET = 1600;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [REQ_W-1:0]   req_type = '0;
    logic [DATA_W-1:0]  push_value = '0;
    logic               busy;
    logic               done;
    logic               ok;
    logic [DATA_W-1:0]  pop_value;
    logic               equal;
    logic [CNT_W-1:0]   count_a;
    logic [CNT_W-1:0]   count_b;
    int                 mismatches;
    int                 outstanding;
    int                 words_sent = 0;
    int                 cycles = 0;

    dual_stack_with_compare u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .push_value (push_value),
        .done       (done),
        .ok         (ok),
        .pop_value  (pop_value),
        .equal      (equal),
        .count_a    (count_a),
        .count_b    (count_b)
    );

    dsc_stack_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .push_value  (push_value),
        .done        (done),
        .ok          (ok),
        .pop_value   (pop_value),
        .equal       (equal),
        .count_a     (count_a),
        .count_b     (count_b),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // one request word; returns at the edge that accepts it
    task automatic send_word(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] val);
        int  gap;
        bit  gaps_on;
        gaps_on = !(words_sent >= 500 && words_sent < 900);
        if (gaps_on && $urandom_range(0, 99) < 10)
        begin
            gap = $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        req_type   <= req;
        push_value <= val;
        do @(posedge clk); while (busy);
        if (req <= REQ_COMPARE)
            words_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0 || busy);
    endtask

    task automatic empty_both();
        int na;
        int nb;
        wait_idle();
        na = int'(count_a);
        nb = int'(count_b);
        repeat (na) send_word(REQ_POP_A, DATA_W'($urandom_range(0, 255)));
        repeat (nb) send_word(REQ_POP_B, DATA_W'($urandom_range(0, 255)));
    endtask

    // fill both stacks with the same bytes, optionally broken, then compare
    task automatic fill_and_compare(input bit broken);
        logic [DATA_W-1:0] bytes_a [STACK_DEPTH];
        logic [DATA_W-1:0] bytes_b [STACK_DEPTH];
        int len_a;
        int len_b;
        int ia;
        int ib;
        int idx;
        empty_both();
        len_a = ($urandom_range(0, 3) == 0) ? STACK_DEPTH : $urandom_range(0, STACK_DEPTH);
        len_b = len_a;
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            bytes_a[i] = DATA_W'($urandom_range(0, 255));
            bytes_b[i] = bytes_a[i];
        end
        if (broken)
        begin
            if (len_a > 0 && $urandom_range(0, 1))
            begin
                idx = $urandom_range(0, len_a - 1);
                bytes_b[idx] = bytes_b[idx] ^ (8'd1 << $urandom_range(0, 7));
            end
            else
                len_b = (len_a == STACK_DEPTH) ? len_a - 1 : len_a + 1;
        end
        ia = 0;
        ib = 0;
        while (ia < len_a || ib < len_b)
        begin
            if (ib >= len_b || (ia < len_a && $urandom_range(0, 1)))
            begin
                send_word(REQ_PUSH_A, bytes_a[ia]);
                ia++;
            end
            else
            begin
                send_word(REQ_PUSH_B, bytes_b[ib]);
                ib++;
            end
        end
        // overflow pushes on a full stack must leave it unchanged
        if (len_a == STACK_DEPTH && $urandom_range(0, 1))
            send_word(REQ_PUSH_A, DATA_W'($urandom_range(0, 255)));
        if (len_b == STACK_DEPTH && $urandom_range(0, 1))
            send_word(REQ_PUSH_B, DATA_W'($urandom_range(0, 255)));
        send_word(REQ_COMPARE, DATA_W'($urandom_range(0, 255)));
    endtask

    // one stack pushed past full, then popped past empty
    task automatic overrun_one();
        logic [REQ_W-1:0] push_req;
        logic [REQ_W-1:0] pop_req;
        int fill;
        if ($urandom_range(0, 1))
        begin
            push_req = REQ_PUSH_A;
            pop_req  = REQ_POP_A;
        end
        else
        begin
            push_req = REQ_PUSH_B;
            pop_req  = REQ_POP_B;
        end
        wait_idle();
        fill = (push_req == REQ_PUSH_A) ? int'(count_a) : int'(count_b);
        repeat (STACK_DEPTH - fill + $urandom_range(1, 3))
            send_word(push_req, DATA_W'($urandom_range(0, 255)));
        repeat (STACK_DEPTH + $urandom_range(1, 3))
            send_word(pop_req, DATA_W'($urandom_range(0, 255)));
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(8, 24))
            send_word(REQ_W'($urandom_range(0, 7)), DATA_W'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int pick;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pops, empty compare, unused codes
        send_word(REQ_POP_A, 8'hFF);
        send_word(REQ_POP_B, 8'hFF);
        send_word(REQ_COMPARE, 8'h00);
        for (int c = REQ_COMPARE + 1; c < 8; c++)
            send_word(REQ_W'(c), 8'hA5);
        // one side empty from the start: nothing popped
        send_word(REQ_PUSH_A, 8'hFF);
        send_word(REQ_COMPARE, 8'h00);
        send_word(REQ_PUSH_B, 8'h00);
        send_word(REQ_POP_B, 8'h00);
        send_word(REQ_POP_A, 8'h00);
        // mismatching pair is consumed
        send_word(REQ_PUSH_A, 8'h55);
        send_word(REQ_PUSH_A, 8'h00);
        send_word(REQ_PUSH_B, 8'hAA);
        send_word(REQ_PUSH_B, 8'h00);
        send_word(REQ_COMPARE, 8'hFF);
        send_word(REQ_PUSH_B, 8'h81);
        send_word(REQ_COMPARE, 8'h7E);
        send_word(REQ_POP_A, 8'h00);
        send_word(REQ_POP_B, 8'h00);

        while (words_sent < WORD_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                fill_and_compare(1'b0);
            else if (pick < 55)
                fill_and_compare(1'b1);
            else if (pick < 70)
                overrun_one();
            else
                noise_burst();
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
